[rtl/core/ddw_pkg.sv]
// Shared constants for the decimal digit display writer.
// Field widths, clamp limit, register addresses and the divide-by-ten reciprocal.
// Depends on nothing; every RTL file refers to it by scoped names.
`default_nettype none

package ddw_pkg;

    localparam int MAX_DIGITS  = 8;
    localparam int VALUE_W     = 32;
    localparam int ADDR_W      = 4;
    localparam int DIGIT_W     = 4;
    localparam int NUM_W       = $clog2(10 ** MAX_DIGITS);
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W       = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    localparam logic [VALUE_W-1:0] CLAMP_LIMIT = VALUE_W'(10 ** MAX_DIGITS - 1);

    localparam logic [ADDR_W-1:0] SCAN_LIMIT_ADDR = 4'd11;

    localparam int RECIP_W     = 32;
    localparam int RECIP_SHIFT = 35;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

    localparam int PROD_W = NUM_W + RECIP_W;

endpackage

`default_nettype wire

[rtl/core/decimal_digit_display_writer_unit.sv]
// Top level of the decimal digit display writer: sequencer, digit store and frame output.
// Depends on ddw_pkg and ddw_div10.
// Sequence: for a number with N significant digits (N from 1 to 8), one division step per
// digit follows the accepting edge; then the registered scan-limit frame comes out, then one
// frame per cycle for the N digits. A new value is taken only once the sequencer is idle,
// paced by the single divide-by-ten unit and the one-frame-per-cycle output register.
// Reset clears the sequencer and the strobe; the receiver cannot stall the frames.
`default_nettype none

module decimal_digit_display_writer_unit
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [ddw_pkg::VALUE_W-1:0]  value,
    output logic                              strobe,
    output logic      [ddw_pkg::ADDR_W-1:0]   reg_address,
    output logic      [ddw_pkg::DIGIT_W-1:0]  reg_data,
    output logic                              last_frame
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [ddw_pkg::NUM_W-1:0]    num_reg, num_next;
    logic [ddw_pkg::IDX_W-1:0]    step_reg, step_next;
    logic [ddw_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [ddw_pkg::CNT_W-1:0]    frame_reg, frame_next;
    logic [ddw_pkg::DIGIT_W-1:0]  digits_reg [ddw_pkg::MAX_DIGITS];
    logic                         strobe_reg, strobe_next;
    logic [ddw_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [ddw_pkg::DIGIT_W-1:0]  data_reg, data_next;
    logic                         last_reg, last_next;

    logic [ddw_pkg::NUM_W-1:0]    quot;
    logic [ddw_pkg::DIGIT_W-1:0]  rem;
    logic [ddw_pkg::VALUE_W-1:0]  clamped;
    logic [ddw_pkg::CNT_W-1:0]    frame_m1;
    logic                         accept;

    ddw_div10 u_div10
    (
        .num  (num_reg),
        .quot (quot),
        .rem  (rem)
    );

    assign accept   = start && (state_reg == ST_IDLE);
    assign clamped  = (value > ddw_pkg::CLAMP_LIMIT) ? ddw_pkg::CLAMP_LIMIT : value;
    assign frame_m1 = frame_reg - 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        num_next    = num_reg;
        step_next   = step_reg;
        count_next  = count_reg;
        frame_next  = frame_reg;
        strobe_next = 1'b0;
        addr_next   = addr_reg;
        data_next   = data_reg;
        last_next   = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    num_next   = clamped[ddw_pkg::NUM_W-1:0];
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                num_next = quot;
                if ((quot == '0) ||
                    (step_reg == ddw_pkg::IDX_W'(ddw_pkg::MAX_DIGITS - 1)))
                begin
                    count_next = ddw_pkg::CNT_W'(step_reg) + 1'b1;
                    frame_next = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                if (frame_reg == '0)
                begin
                    addr_next = ddw_pkg::SCAN_LIMIT_ADDR;
                    data_next = ddw_pkg::DIGIT_W'(count_reg - 1'b1);
                    last_next = 1'b0;
                end
                else
                begin
                    addr_next = ddw_pkg::ADDR_W'(frame_reg);
                    data_next = digits_reg[frame_m1[ddw_pkg::IDX_W-1:0]];
                    last_next = (frame_reg == count_reg);
                end
                if (frame_reg == count_reg)
                begin
                    state_next = ST_IDLE;
                end
                frame_next = frame_reg + 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            step_reg   <= '0;
            count_reg  <= '0;
            frame_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            step_reg   <= step_next;
            count_reg  <= count_next;
            frame_reg  <= frame_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        addr_reg <= addr_next;
        data_reg <= data_next;
        last_reg <= last_next;
        if (state_reg == ST_DIV)
        begin
            digits_reg[step_reg] <= rem;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign strobe      = strobe_reg;
    assign reg_address = addr_reg;
    assign reg_data    = data_reg;
    assign last_frame  = last_reg;

    // An accepted transfer always starts the division phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_DIV))
        else $error("accepted transfer did not start division");

    // Frames of one item come out in consecutive cycles until the last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last_frame) |=> strobe)
        else $error("gap inside a frame sequence");

    // The scan-limit frame is never the last frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (reg_address == ddw_pkg::SCAN_LIMIT_ADDR)) |-> !last_frame)
        else $error("scan-limit frame marked last");

    // Digit frames address a digit position and carry a decimal digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (reg_address != ddw_pkg::SCAN_LIMIT_ADDR)) |->
            ((reg_address != '0) &&
             (reg_address <= ddw_pkg::ADDR_W'(ddw_pkg::MAX_DIGITS)) &&
             (reg_data <= ddw_pkg::DIGIT_W'(9))))
        else $error("digit frame out of range");

endmodule

`default_nettype wire

[rtl/core/ddw_div10.sv]
// Divide-by-ten unit shared by every digit step of the sequencer.
// Uses a reciprocal multiply and a shift-add remainder; depends on ddw_pkg.
`default_nettype none

module ddw_div10
(
    input  wire logic [ddw_pkg::NUM_W-1:0]   num,
    output logic      [ddw_pkg::NUM_W-1:0]   quot,
    output logic      [ddw_pkg::DIGIT_W-1:0] rem
);

    logic [ddw_pkg::PROD_W-1:0] prod;
    logic [ddw_pkg::NUM_W-1:0]  ten_q;
    logic [ddw_pkg::NUM_W-1:0]  diff;

    always_comb
    begin
        prod  = ddw_pkg::PROD_W'(num) * ddw_pkg::PROD_W'(ddw_pkg::RECIP_TEN);
        quot  = ddw_pkg::NUM_W'(prod >> ddw_pkg::RECIP_SHIFT);
        ten_q = (quot << 3) + (quot << 1);
        diff  = num - ten_q;
        rem   = diff[ddw_pkg::DIGIT_W-1:0];
    end

endmodule

`default_nettype wire
